// ----- rtl/modbus_rtu_coil_request_engine_core_defines.svh -----
// Assertion helpers for the RTL.
`ifndef MODBUS_RTU_COIL_REQUEST_ENGINE_CORE_DEFINES_SVH
`define MODBUS_RTU_COIL_REQUEST_ENGINE_CORE_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define MRCE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define MRCE_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/mrce_pkg.sv -----
`timescale 1ns / 1ps

package mrce_pkg;

  localparam int RX_BYTES  = 8;
  localparam int FRAME_LEN = 8;
  localparam int RX_CW     = $clog2(RX_BYTES + 1);
  localparam int RX_AW     = $clog2(RX_BYTES);
  localparam int FRAME_AW  = $clog2(FRAME_LEN);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FC_WRITE_COIL = 8'h05;
  localparam logic [7:0] FC_READ_COILS = 8'h01;
  localparam logic [7:0] COIL_ON_VAL   = 8'hFF;
  localparam logic [7:0] READ_QTY      = 8'h08;

  localparam int MIN_READ_LEN = 5;

  localparam logic OUT_TX     = 1'b0;
  localparam logic OUT_STATUS = 1'b1;

  typedef enum logic [1:0] {
    REQ_WRITE    = 2'd0,
    REQ_READ     = 2'd1,
    REQ_RX_BYTE  = 2'd2,
    REQ_RESP_END = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_BUSY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_SLAVE_ADDR  = 2'd0,
    CFG_RELAY_COUNT = 2'd1,
    CFG_RETRY_LIMIT = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BUILD,
    S_CRC_STORE,
    S_SEND,
    S_CHECK,
    S_DECIDE,
    S_STATUS
  } state_t;

  typedef struct packed {
    logic init;
    logic update;
  } crc_ctl_t;

endpackage

// ----- rtl/mrce_ram.sv -----
`timescale 1ns / 1ps

module mrce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/mrce_crc_unit.sv -----
`timescale 1ns / 1ps

module mrce_crc_unit
  import mrce_pkg::*;
(
  input  logic        clk,
  input  crc_ctl_t    ctl,
  input  logic [7:0]  data,
  output logic [15:0] crc
);

  // one byte per cycle, reflected CRC16
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] d);
    logic [15:0] c;
    c = c_in ^ {8'h00, d};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      crc <= CRC_INIT;
    end else if (ctl.update) begin
      crc <= crc_byte(crc, data);
    end
  end

endmodule

// ----- rtl/modbus_rtu_coil_request_engine_core.sv -----
// Modbus RTU master for relay coil requests.
// cfg channel: cfg_index selects slave_addr (0), relay_count (1) or retry_limit (2);
//   always ready, write only while the engine is idle.
// in channel: one item per transaction; req_type picks write coil, read coils,
//   received byte or response end. in_ready is high only while the sequencer is idle.
// out channel: a registered result slot; transmit bytes (eight per frame, last on
//   the eighth) or one final status. A stalled receiver holds the slot and the
//   sequencer waits; nothing is dropped.
// Timing: a command builds the frame through the shared CRC unit, stores the CRC,
//   then sends the eight bytes.
//   A response end with link_ok and enough bytes scans the buffered bytes one
//   per cycle through the same unit and then decides; a response end without
//   them goes straight to the decision, which resends the frame or sends one status.
//   The rate is set by the single CRC unit and the one read port of the rx buffer.
// Reset: registers return to slave 1, 8 relays, 3 attempts; no transaction open,
//   buffer empty, output slot empty. The buffers need no clearing pass.
`timescale 1ns / 1ps
`include "modbus_rtu_coil_request_engine_core_defines.svh"

module modbus_rtu_coil_request_engine_core
  import mrce_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] req_type,
  input  logic [7:0] channel,
  input  logic       coil_on,
  input  logic [7:0] rx_byte,
  input  logic       link_ok,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] tx_byte,
  output logic       last,
  output logic       is_retry,
  output logic [1:0] status,
  output logic [7:0] coil_states
);

  state_t state, state_next;

  logic [7:0] slave_addr;
  logic [3:0] relay_count;
  logic [2:0] retry_limit;

  logic             waiting;
  logic             op_is_read;
  logic [2:0]       attempt_count;
  logic [RX_CW-1:0] rx_count;
  logic             resend;

  logic [7:0] frame_store [FRAME_LEN];
  logic       cmd_read;
  logic [7:0] cmd_b3, cmd_b4, cmd_b5;

  logic [RX_CW-1:0] idx;
  logic [RX_CW-1:0] rd_idx;
  logic             rd_vld;
  logic             chk_ok;
  logic [7:0]       coils;
  status_t          status_code;

  logic [15:0] crc;
  crc_ctl_t    crc_ctl;
  logic [7:0]  crc_data;
  logic [7:0]  ram_rdata;

  logic             in_fire, out_slot;
  logic             is_cmd, chan_bad, start_cmd, reject, rx_wr, resp, resp_pre;
  logic [RX_CW-1:0] n_len, min_len;
  logic [7:0]       build_byte;
  logic [FRAME_AW-1:0] frd_idx;
  logic [7:0]       frd;
  logic             load_tx, load_status;
  logic             retry_ok;

  // ---------------- decode ----------------
  assign in_fire  = in_valid && in_ready;
  assign out_slot = !out_valid || out_ready;
  assign n_len    = op_is_read ? rx_count : RX_CW'(FRAME_LEN);
  assign min_len  = op_is_read ? RX_CW'(MIN_READ_LEN) : RX_CW'(FRAME_LEN);

  assign is_cmd    = (req_type == REQ_WRITE) || (req_type == REQ_READ);
  assign chan_bad  = (channel == 8'd0) || (channel > {4'd0, relay_count});
  assign start_cmd = in_fire && is_cmd && !waiting &&
                     ((req_type == REQ_READ) || !chan_bad);
  assign reject    = in_fire && is_cmd &&
                     (waiting || ((req_type == REQ_WRITE) && chan_bad));
  assign rx_wr     = in_fire && (req_type == REQ_RX_BYTE) && waiting &&
                     (rx_count < RX_CW'(RX_BYTES));
  assign resp      = in_fire && (req_type == REQ_RESP_END) && waiting;
  assign resp_pre  = link_ok && (rx_count >= min_len);
  assign retry_ok  = attempt_count < retry_limit;

  always_comb begin
    case (idx[FRAME_AW-1:0])
      3'd0:    build_byte = slave_addr;
      3'd1:    build_byte = cmd_read ? FC_READ_COILS : FC_WRITE_COIL;
      3'd3:    build_byte = cmd_b3;
      3'd4:    build_byte = cmd_b4;
      3'd5:    build_byte = cmd_b5;
      default: build_byte = 8'h00;
    endcase
  end

  // single frame store read port: scan compare or send
  assign frd_idx = (state == S_CHECK) ? rd_idx[FRAME_AW-1:0] : idx[FRAME_AW-1:0];
  assign frd     = frame_store[frd_idx];

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (req_t'(req_type))
            REQ_WRITE, REQ_READ: state_next = reject ? S_STATUS : S_BUILD;
            REQ_RX_BYTE:         state_next = S_IDLE;
            REQ_RESP_END: begin
              if (waiting) begin
                state_next = resp_pre ? S_CHECK : S_DECIDE;
              end
            end
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_BUILD: begin
        if (idx[FRAME_AW-1:0] == FRAME_AW'(FRAME_LEN - 3)) begin
          state_next = S_CRC_STORE;
        end
      end
      S_CRC_STORE: state_next = S_SEND;
      S_SEND: begin
        if (out_slot && (idx[FRAME_AW-1:0] == FRAME_AW'(FRAME_LEN - 1))) begin
          state_next = S_IDLE;
        end
      end
      S_CHECK: begin
        if (rd_vld && (rd_idx == n_len - RX_CW'(1))) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: state_next = (!chk_ok && retry_ok) ? S_SEND : S_STATUS;
      S_STATUS: begin
        if (out_slot) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    in_ready       = (state == S_IDLE);
    cfg_ready      = 1'b1;
    load_tx        = (state == S_SEND) && out_slot;
    load_status    = (state == S_STATUS) && out_slot;
    crc_ctl.init   = start_cmd || resp;
    crc_ctl.update = (state == S_BUILD) ||
                     ((state == S_CHECK) && rd_vld && (rd_idx < n_len - RX_CW'(2)));
    crc_data       = (state == S_BUILD) ? build_byte : ram_rdata;
  end

  // ---------------- shared units ----------------
  mrce_crc_unit u_crc (
    .clk  (clk),
    .ctl  (crc_ctl),
    .data (crc_data),
    .crc  (crc)
  );

  mrce_ram #(
    .WIDTH (8),
    .DEPTH (RX_BYTES)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_wr),
    .waddr (rx_count[RX_AW-1:0]),
    .wdata (rx_byte),
    .raddr (idx[RX_AW-1:0]),
    .rdata (ram_rdata)
  );

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_addr  <= 8'd1;
      relay_count <= 4'd8;
      retry_limit <= 3'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_SLAVE_ADDR:  slave_addr  <= cfg_data;
        CFG_RELAY_COUNT: relay_count <= cfg_data[3:0];
        CFG_RETRY_LIMIT: retry_limit <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting       <= 1'b0;
      op_is_read    <= 1'b0;
      attempt_count <= 3'd0;
      rx_count      <= '0;
      resend        <= 1'b0;
    end else begin
      if (start_cmd) begin
        waiting       <= 1'b1;
        op_is_read    <= (req_type == REQ_READ);
        attempt_count <= 3'd1;
        rx_count      <= '0;
        resend        <= 1'b0;
      end
      if (rx_wr) begin
        rx_count <= rx_count + RX_CW'(1);
      end
      if (state == S_DECIDE) begin
        if (!chk_ok && retry_ok) begin
          attempt_count <= attempt_count + 3'd1;
          rx_count      <= '0;
          resend        <= 1'b1;
        end else begin
          waiting <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == S_CHECK) && (idx < n_len);
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= idx;

    if (start_cmd) begin
      cmd_read <= (req_type == REQ_READ);
      if (req_type == REQ_READ) begin
        cmd_b3 <= 8'h00;
        cmd_b4 <= 8'h00;
        cmd_b5 <= READ_QTY;
      end else begin
        cmd_b3 <= channel - 8'd1;
        cmd_b4 <= coil_on ? COIL_ON_VAL : 8'h00;
        cmd_b5 <= 8'h00;
      end
    end

    case (state)
      S_IDLE:      idx <= '0;
      S_BUILD: begin
        frame_store[idx[FRAME_AW-1:0]] <= build_byte;
        idx <= idx + RX_CW'(1);
      end
      S_CRC_STORE: begin
        frame_store[FRAME_LEN-2] <= crc[7:0];
        frame_store[FRAME_LEN-1] <= crc[15:8];
        idx <= '0;
      end
      S_SEND: begin
        if (out_slot) begin
          idx <= idx + RX_CW'(1);
        end
      end
      S_CHECK: begin
        if (idx < n_len) begin
          idx <= idx + RX_CW'(1);
        end
      end
      default:     idx <= '0;
    endcase

    if (resp) begin
      chk_ok <= resp_pre;
      coils  <= 8'h00;
    end else if ((state == S_CHECK) && rd_vld) begin
      // CRC register is final once the byte at n-2 arrives
      if ((rd_idx == n_len - RX_CW'(2)) && (ram_rdata != crc[7:0])) begin
        chk_ok <= 1'b0;
      end
      if ((rd_idx == n_len - RX_CW'(1)) && (ram_rdata != crc[15:8])) begin
        chk_ok <= 1'b0;
      end
      if (op_is_read) begin
        if ((rd_idx == RX_CW'(0)) && (ram_rdata != frd)) begin
          chk_ok <= 1'b0;
        end
        if ((rd_idx == RX_CW'(1)) && (ram_rdata != FC_READ_COILS)) begin
          chk_ok <= 1'b0;
        end
        if (rd_idx == RX_CW'(3)) begin
          coils <= ram_rdata;
        end
      end else if ((rd_idx < RX_CW'(4)) && (ram_rdata != frd)) begin
        chk_ok <= 1'b0;
      end
    end

    if (reject) begin
      status_code <= waiting ? ST_BUSY : ST_INVALID;
    end else if (state == S_DECIDE) begin
      status_code <= chk_ok ? ST_OK : ST_TIMEOUT;
    end
  end

  // output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_tx || load_status) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_tx) begin
      out_kind    <= OUT_TX;
      tx_byte     <= frd;
      last        <= (idx[FRAME_AW-1:0] == FRAME_AW'(FRAME_LEN - 1));
      is_retry    <= resend;
      status      <= ST_OK;
      coil_states <= 8'h00;
    end else if (load_status) begin
      out_kind    <= OUT_STATUS;
      tx_byte     <= 8'h00;
      last        <= 1'b0;
      is_retry    <= 1'b0;
      status      <= status_code;
      coil_states <= (status_code == ST_OK) ? coils : 8'h00;
    end
  end

  // ---------------- assertions ----------------
  `MRCE_ASSERT_ALWAYS(a_rx_count_bound, rx_count <= RX_CW'(RX_BYTES), "rx_count beyond buffer")
  `MRCE_ASSERT_IMPLIES(a_attempt_nonzero, waiting, attempt_count != 3'd0, "open request with no attempt")
  `MRCE_ASSERT_IMPLIES(a_send_needs_request, state == S_SEND, waiting, "frame sent with no open request")
  `MRCE_ASSERT_IMPLIES(a_scan_in_range, rd_vld, rd_idx < n_len, "scan read past response length")

endmodule

// ----- dv/modbus_rtu_coil_request_engine_core_tb.sv -----
`timescale 1ns / 1ps

module modbus_rtu_coil_request_engine_core_tb;
  import mrce_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned SETTLE_CYCLES   = 24;
  localparam int unsigned ITEMS_PER_PHASE = 16;
  localparam logic [1:0]  CFG_UNUSED      = 2'd3;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    req_t       req;
    logic [7:0] ch;
    logic       on;
    logic [7:0] rxb;
    logic       link;
  } cmd_t;

  typedef struct {
    logic       kind;
    logic [7:0] tx;
    logic       lst;
    logic       retry;
    status_t    st;
    logic [7:0] coils;
  } result_t;

  // how an rx byte of the directed table gets its value
  typedef enum logic [1:0] {
    FILL_LIT,
    FILL_ECHO,
    FILL_CRC_LO,
    FILL_CRC_HI
  } fill_t;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_STATUS
  } check_t;

  typedef struct {
    cmd_t       c;
    fill_t      fill;
    check_t     chk;
    status_t    st;
    logic [7:0] coils;
  } plan_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] req_type;
  logic [7:0] channel;
  logic       coil_on;
  logic [7:0] rx_byte;
  logic       link_ok;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_kind;
  logic [7:0] tx_byte;
  logic       last;
  logic       is_retry;
  logic [1:0] status;
  logic [7:0] coil_states;

  // predictor state
  logic [7:0] model_addr;
  logic [3:0] model_relay;
  logic [2:0] model_retry;
  logic [2:0] model_attempts;
  logic       model_busy;
  logic       model_read;
  byte_q_t    frame_q;
  byte_q_t    rx_q;

  result_t     step_out[$];
  result_t     engine_out_q[$];
  plan_row_t   plan[$];
  int unsigned live_items = 0;
  int unsigned fails = 0;
  int unsigned cycle_count = 0;
  int unsigned rdy_left = 0;
  bit          calm = 1'b0;
  bit          sender_steady = 1'b0;

  modbus_rtu_coil_request_engine_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .channel     (channel),
    .coil_on     (coil_on),
    .rx_byte     (rx_byte),
    .link_ok     (link_ok),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .tx_byte     (tx_byte),
    .last        (last),
    .is_retry    (is_retry),
    .status      (status),
    .coil_states (coil_states)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("modbus_rtu_coil_request_engine_core: mismatch");
      $finish;
    end
  end

  // receiver back-pressure in bursts; none once calm
  always @(posedge clk) begin
    if (rdy_left != 0) begin
      rdy_left <= rdy_left - 1;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      case ($urandom_range(0, 5))
        0, 1: begin
          out_ready <= 1'b0;
          rdy_left  <= $urandom_range(1, 9);
        end
        2: begin
          out_ready <= 1'b1;
          rdy_left  <= $urandom_range(10, 40);
        end
        default: begin
          out_ready <= 1'b1;
          rdy_left  <= $urandom_range(1, 9);
        end
      endcase
    end
  end

  function automatic logic [15:0] crc16_of(byte_q_t b, int unsigned n);
    logic [15:0] crc;
    crc = CRC_INIT;
    for (int unsigned i = 0; i < n; i++) begin
      crc = crc ^ {8'h00, b[i]};
      for (int k = 0; k < 8; k++) begin
        if (crc[0]) crc = (crc >> 1) ^ CRC_POLY;
        else crc = crc >> 1;
      end
    end
    return crc;
  endfunction

  function automatic result_t status_result(status_t s, logic [7:0] coils);
    result_t r;
    r = '{OUT_STATUS, 8'h00, 1'b0, 1'b0, s, coils};
    return r;
  endfunction

  function automatic void send_frame(logic retry);
    rx_q.delete();
    foreach (frame_q[i])
      step_out.push_back('{OUT_TX, frame_q[i], i == FRAME_LEN - 1, retry, ST_OK, 8'h00});
  endfunction

  function automatic void set_reg(logic [1:0] idx, logic [7:0] v);
    case (idx)
      CFG_SLAVE_ADDR:  model_addr  = v;
      CFG_RELAY_COUNT: model_relay = v[3:0];
      CFG_RETRY_LIMIT: model_retry = v[2:0];
      default: ;
    endcase
  endfunction

  // expected engine output for one accepted transaction
  function automatic void coil_engine_step(cmd_t c);
    logic        good;
    logic [7:0]  coils;
    logic [15:0] crc;
    int unsigned n;
    step_out.delete();
    good  = 1'b0;
    coils = 8'h00;
    n     = rx_q.size();
    case (c.req)
      REQ_WRITE, REQ_READ: begin
        if (model_busy) begin
          step_out.push_back(status_result(ST_BUSY, 8'h00));
        end else if (c.req == REQ_WRITE && (c.ch == 8'd0 || c.ch > model_relay)) begin
          step_out.push_back(status_result(ST_INVALID, 8'h00));
        end else begin
          model_read = (c.req == REQ_READ);
          frame_q.delete();
          frame_q.push_back(model_addr);
          frame_q.push_back(model_read ? FC_READ_COILS : FC_WRITE_COIL);
          frame_q.push_back(8'h00);
          frame_q.push_back(model_read ? 8'h00 : c.ch - 8'd1);
          frame_q.push_back((!model_read && c.on) ? COIL_ON_VAL : 8'h00);
          frame_q.push_back(model_read ? READ_QTY : 8'h00);
          crc = crc16_of(frame_q, 6);
          frame_q.push_back(crc[7:0]);
          frame_q.push_back(crc[15:8]);
          model_busy     = 1'b1;
          model_attempts = 3'd1;
          send_frame(1'b0);
        end
      end
      REQ_RX_BYTE: begin
        if (model_busy && n < RX_BYTES) rx_q.push_back(c.rxb);
      end
      default: begin
        if (model_busy) begin
          if (model_read) begin
            if (c.link && n >= MIN_READ_LEN) begin
              crc  = crc16_of(rx_q, n - 2);
              good = rx_q[n-2] == crc[7:0] && rx_q[n-1] == crc[15:8] &&
                     rx_q[0] == frame_q[0] && rx_q[1] == FC_READ_COILS;
              if (good) coils = rx_q[3];
            end
          end else if (c.link && n >= FRAME_LEN) begin
            // write echo: judged on the first eight bytes only
            crc  = crc16_of(rx_q, 6);
            good = rx_q[6] == crc[7:0] && rx_q[7] == crc[15:8] &&
                   rx_q[0] == frame_q[0] && rx_q[1] == frame_q[1] &&
                   rx_q[2] == frame_q[2] && rx_q[3] == frame_q[3];
          end
          if (good) begin
            model_busy = 1'b0;
            step_out.push_back(status_result(ST_OK, coils));
          end else if (model_attempts < model_retry) begin
            model_attempts = model_attempts + 3'd1;
            send_frame(1'b1);
          end else begin
            model_busy = 1'b0;
            step_out.push_back(status_result(ST_TIMEOUT, 8'h00));
          end
        end
      end
    endcase
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s expected %02h, actual %02h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch_out
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (engine_out_q.size() == 0) begin
        fails++;
        $display("%0t: expected no result, actual kind %0b tx %02h status %0d coils %02h",
                 $time, out_kind, tx_byte, status, coil_states);
      end else begin
        want = engine_out_q.pop_front();
        compare_field("out_kind", 8'(want.kind), 8'(out_kind));
        compare_field("tx_byte", want.tx, tx_byte);
        compare_field("last", 8'(want.lst), 8'(last));
        compare_field("is_retry", 8'(want.retry), 8'(is_retry));
        compare_field("status", 8'(want.st), 8'(status));
        compare_field("coil_states", want.coils, coil_states);
      end
    end
  end

  function automatic cmd_t any_item(req_t r);
    cmd_t c;
    c.req  = r;
    c.ch   = 8'($urandom);
    c.on   = 1'($urandom);
    c.rxb  = 8'($urandom);
    c.link = 1'($urandom);
    return c;
  endfunction

  function automatic plan_row_t mk(req_t r, logic [7:0] ch, logic on, logic [7:0] rxb,
                                   logic link, fill_t f, check_t k,
                                   status_t s = ST_OK, logic [7:0] coils = 8'h00);
    plan_row_t p;
    p.c     = '{r, ch, on, rxb, link};
    p.fill  = f;
    p.chk   = k;
    p.st    = s;
    p.coils = coils;
    return p;
  endfunction

  task automatic send_item(input cmd_t c, input check_t chk = CHK_MODEL,
                           input status_t st = ST_OK, input logic [7:0] coils = 8'h00);
    if (!calm && !sender_steady && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= c.req;
    channel  <= c.ch;
    coil_on  <= c.on;
    rx_byte  <= c.rxb;
    link_ok  <= c.link;
    do @(posedge clk); while (!in_ready);
    if (c.req == REQ_WRITE || c.req == REQ_READ || model_busy) live_items++;
    coil_engine_step(c);
    case (chk)
      CHK_MODEL:  foreach (step_out[i]) engine_out_q.push_back(step_out[i]);
      CHK_STATUS: engine_out_q.push_back(status_result(st, coils));
      default: ;
    endcase
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    set_reg(idx, v);
  endtask

  // stop sending until every expected result is out, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (engine_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // feed slave responses, mostly good, until the open transaction closes
  task automatic answer_pending();
    byte_q_t     resp;
    logic [15:0] crc;
    logic        link;
    int unsigned n;
    int unsigned k;
    cmd_t        c;
    while (model_busy) begin
      resp.delete();
      if (model_read) begin
        n = $urandom_range(0, 3);
        resp.push_back(frame_q[0]);
        resp.push_back(FC_READ_COILS);
        resp.push_back(8'(n));
        repeat (n) resp.push_back(8'($urandom));
        crc = crc16_of(resp, resp.size());
        resp.push_back(crc[7:0]);
        resp.push_back(crc[15:8]);
      end else begin
        resp = frame_q;
      end
      link = 1'b1;
      case ($urandom_range(0, 9))
        0: begin
          k = $urandom_range(0, resp.size() - 1);
          resp[k] = resp[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        1: link = 1'b0;
        2: repeat ($urandom_range(1, resp.size())) void'(resp.pop_back());
        3: repeat ($urandom_range(1, 3)) resp.push_back(8'($urandom));
        default: ;
      endcase
      foreach (resp[i]) begin
        if ($urandom_range(0, 19) == 0)
          send_item(any_item($urandom_range(0, 1) ? REQ_READ : REQ_WRITE));
        c = any_item(REQ_RX_BYTE);
        c.rxb = resp[i];
        send_item(c);
      end
      c = any_item(REQ_RESP_END);
      c.link = link;
      send_item(c);
    end
  endtask

  task automatic random_burst();
    cmd_t c;
    sender_steady = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) < 7) begin
      c = any_item($urandom_range(0, 2) == 0 ? REQ_READ : REQ_WRITE);
      if ($urandom_range(0, 3) != 0) c.ch = 8'($urandom_range(0, model_relay + 1));
      send_item(c);
      answer_pending();
    end else begin
      send_item(any_item(req_t'($urandom_range(0, 3))));
    end
  endtask

  task automatic run_phase(input logic [7:0] addr, input logic [7:0] relay,
                           input logic [7:0] retry, input bit tail);
    int unsigned goal;
    drain();
    write_reg(CFG_SLAVE_ADDR, addr);
    write_reg(CFG_RELAY_COUNT, relay);
    write_reg(CFG_RETRY_LIMIT, retry);
    write_reg(CFG_UNUSED, 8'($urandom));
    cfg_valid <= 1'b0;
    calm = tail;
    goal = live_items + ITEMS_PER_PHASE;
    while (live_items < goal) begin
      random_burst();
      if (!tail && $urandom_range(0, 29) == 0) drain();
    end
  endtask

  initial begin : stimulus
    cmd_t        c;
    logic [15:0] crc;
    byte_q_t     sent_resp;
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_SLAVE_ADDR;
    cfg_data  <= 8'h00;
    in_valid  <= 1'b0;
    req_type  <= REQ_WRITE;
    channel   <= 8'h00;
    coil_on   <= 1'b0;
    rx_byte   <= 8'h00;
    link_ok   <= 1'b0;
    model_addr     = 8'd1;
    model_relay    = 4'd8;
    model_retry    = 3'd3;
    model_attempts = 3'd0;
    model_busy     = 1'b0;
    model_read     = 1'b0;

    // directed: reset values slave 1, 8 relays, 3 attempts
    plan.push_back(mk(REQ_WRITE, 8'd0, 1'b1, 8'h00, 1'b1, FILL_LIT, CHK_STATUS, ST_INVALID));
    plan.push_back(mk(REQ_WRITE, 8'd9, 1'b1, 8'hFF, 1'b0, FILL_LIT, CHK_STATUS, ST_INVALID));
    plan.push_back(mk(REQ_RX_BYTE, 8'hFF, 1'b1, 8'hFF, 1'b1, FILL_LIT, CHK_NONE));
    plan.push_back(mk(REQ_RESP_END, 8'h00, 1'b0, 8'h00, 1'b1, FILL_LIT, CHK_NONE));
    plan.push_back(mk(REQ_WRITE, 8'd8, 1'b0, 8'h00, 1'b0, FILL_LIT, CHK_MODEL));
    plan.push_back(mk(REQ_WRITE, 8'd1, 1'b1, 8'h00, 1'b0, FILL_LIT, CHK_STATUS, ST_BUSY));
    plan.push_back(mk(REQ_READ, 8'd1, 1'b0, 8'h00, 1'b0, FILL_LIT, CHK_STATUS, ST_BUSY));
    plan.push_back(mk(REQ_RESP_END, 8'h00, 1'b0, 8'h00, 1'b0, FILL_LIT, CHK_MODEL));
    plan.push_back(mk(REQ_RESP_END, 8'h00, 1'b0, 8'h00, 1'b1, FILL_LIT, CHK_MODEL));
    plan.push_back(mk(REQ_RESP_END, 8'h00, 1'b0, 8'h00, 1'b1, FILL_LIT, CHK_STATUS,
                      ST_TIMEOUT));
    plan.push_back(mk(REQ_WRITE, 8'd1, 1'b1, 8'h00, 1'b0, FILL_LIT, CHK_MODEL));
    for (int i = 0; i < FRAME_LEN; i++)
      plan.push_back(mk(REQ_RX_BYTE, 8'h00, 1'b0, 8'(i), 1'b0, FILL_ECHO, CHK_NONE));
    plan.push_back(mk(REQ_RESP_END, 8'h00, 1'b0, 8'h00, 1'b1, FILL_LIT, CHK_STATUS, ST_OK));
    plan.push_back(mk(REQ_READ, 8'h00, 1'b0, 8'h00, 1'b0, FILL_LIT, CHK_MODEL));
    plan.push_back(mk(REQ_RX_BYTE, 8'h00, 1'b0, 8'd0, 1'b0, FILL_ECHO, CHK_NONE));
    plan.push_back(mk(REQ_RX_BYTE, 8'h00, 1'b0, FC_READ_COILS, 1'b0, FILL_LIT, CHK_NONE));
    plan.push_back(mk(REQ_RX_BYTE, 8'h00, 1'b0, 8'h01, 1'b0, FILL_LIT, CHK_NONE));
    plan.push_back(mk(REQ_RX_BYTE, 8'h00, 1'b0, 8'hA5, 1'b0, FILL_LIT, CHK_NONE));
    plan.push_back(mk(REQ_RX_BYTE, 8'h00, 1'b0, 8'h00, 1'b0, FILL_CRC_LO, CHK_NONE));
    plan.push_back(mk(REQ_RX_BYTE, 8'h00, 1'b0, 8'h00, 1'b0, FILL_CRC_HI, CHK_NONE));
    plan.push_back(mk(REQ_RESP_END, 8'h00, 1'b0, 8'h00, 1'b1, FILL_LIT, CHK_STATUS, ST_OK,
                      8'hA5));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      c = plan[i].c;
      case (plan[i].fill)
        FILL_ECHO: c.rxb = frame_q[plan[i].c.rxb];
        FILL_CRC_LO: begin
          crc   = crc16_of(sent_resp, sent_resp.size());
          c.rxb = crc[7:0];
        end
        FILL_CRC_HI: begin
          // low byte already sent, leave it out of the sum
          crc   = crc16_of(sent_resp, sent_resp.size() - 1);
          c.rxb = crc[15:8];
        end
        default: ;
      endcase
      if (c.req == REQ_RX_BYTE) sent_resp.push_back(c.rxb);
      else sent_resp.delete();
      send_item(c, plan[i].chk, plan[i].st, plan[i].coils);
    end

    run_phase(8'd247, 8'h01, 8'h01, 1'b0);
    run_phase(8'hFF, 8'hFF, 8'hFF, 1'b0);
    // zero relays rejects every write; zero retries acts as a single attempt
    run_phase(8'h00, 8'hF0, 8'hF8, 1'b0);
    run_phase(8'($urandom_range(1, 247)), 8'($urandom_range(1, 8)),
              8'($urandom_range(1, 7)), 1'b1);

    drain();
    if (fails == 0)
      $display("modbus_rtu_coil_request_engine_core: match");
    else
      $display("modbus_rtu_coil_request_engine_core: mismatch");
    $finish;
  end

endmodule
